@@ sv/bsc_pkg.sv @@
// Shared constants and control/status types for the counting bubble sorter.
package bsc_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 32;
  localparam int TOTAL_W   = 11;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;       // write the input item at the fill position
    logic pass_start;  // read the top entry, clear the pass swap flag
    logic pass_first;  // capture the top entry, read the one below
    logic step;        // compare, write back, read the next lower entry
    logic pass_end;    // write the carried value, advance the pass
    logic out_read;    // read the entry at the output index
    logic out_next;    // advance the output index
    logic clear;       // return control state to its reset values
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic no_pass;     // current pass would make no comparison
    logic last_step;   // current step is the last one of the pass
    logic swapped;     // a swap happened in the current pass
    logic out_last;    // output index is on the final entry
  } sts_t;

endpackage

@@ sv/bsc_if.sv @@
// Valid/ready channel interfaces for the input and result items.
interface bsc_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [bsc_pkg::VAL_W-1:0] item_value;
  logic                             is_last;

  modport source (output valid, output item_value, output is_last, input ready);
  modport sink   (input valid, input item_value, input is_last, output ready);
endinterface

interface bsc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bsc_pkg::VAL_W-1:0]   sorted_value;
  logic                               last_out;
  logic        [bsc_pkg::TOTAL_W-1:0] compare_total;
  logic        [bsc_pkg::TOTAL_W-1:0] swap_total;

  modport source (output valid, output sorted_value, output last_out,
                  output compare_total, output swap_total, input ready);
  modport sink   (input valid, input sorted_value, input last_out,
                  input compare_total, input swap_total, output ready);
endinterface

@@ sv/bsc_ctrl.sv @@
// Sequencer for load, bubble-sort passes and output of one set.
module bsc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_is_last,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bsc_pkg::sts_t sts,
  output bsc_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_PSTART,
    S_PFIRST,
    S_STEP,
    S_PEND,
    S_ORD,
    S_OWAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid && in_ready_r) begin
          cmd.store = 1'b1;
          if (in_is_last) begin
            in_ready_nxt = 1'b0;
            state_nxt    = S_PSTART;
          end
        end
      end
      S_PSTART: begin
        if (sts.no_pass) begin
          state_nxt = S_ORD;
        end else begin
          cmd.pass_start = 1'b1;
          state_nxt      = S_PFIRST;
        end
      end
      S_PFIRST: begin
        cmd.pass_first = 1'b1;
        state_nxt      = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (sts.last_step) begin
          state_nxt = S_PEND;
        end
      end
      S_PEND: begin
        cmd.pass_end = 1'b1;
        state_nxt    = sts.swapped ? S_PSTART : S_ORD;
      end
      S_ORD: begin
        cmd.out_read  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (sts.out_last) begin
            cmd.clear    = 1'b1;
            in_ready_nxt = 1'b1;
            state_nxt    = S_LOAD;
          end else begin
            cmd.out_next = 1'b1;
            state_nxt    = S_ORD;
          end
        end
      end
      default: begin
        state_nxt     = S_LOAD;
        in_ready_nxt  = 1'b1;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready_r && out_valid_r))
    else $error("input ready while a result is shown");

  // The result is shown exactly while the controller waits on the receiver.
  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r == (state_r == S_OWAIT))
    else $error("result valid out of step with the sequencer");

endmodule

@@ sv/bsc_dp.sv @@
// Value store, pass/step indexes, carried value and comparison counters.
module bsc_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bsc_pkg::cmd_t                        cmd,
  output bsc_pkg::sts_t                        sts,
  input  logic signed [bsc_pkg::VAL_W-1:0]     in_value,
  output logic signed [bsc_pkg::VAL_W-1:0]     out_value,
  output logic                                 out_last,
  output logic        [bsc_pkg::TOTAL_W-1:0]   out_compares,
  output logic        [bsc_pkg::TOTAL_W-1:0]   out_swaps
);

  localparam int AW = bsc_pkg::ADDR_W;
  localparam int CW = bsc_pkg::CNT_W;
  localparam int VW = bsc_pkg::VAL_W;
  localparam int TW = bsc_pkg::TOTAL_W;

  logic signed [VW-1:0] store_mem [bsc_pkg::MAX_ITEMS];
  logic signed [VW-1:0] rdata_r;
  logic signed [VW-1:0] cur_r, cur_nxt;

  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] pass_r, pass_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          swapped_r, swapped_nxt;
  logic [TW-1:0] cmp_r, cmp_nxt;
  logic [TW-1:0] swp_r, swp_nxt;

  logic [CW-1:0] fill_m1;
  logic          full;
  logic          swap_now;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  assign fill_m1  = fill_r - CW'(1);
  assign full     = (fill_r == CW'(bsc_pkg::MAX_ITEMS));
  // Value carried from above sinks past the entry just read.
  assign swap_now = (cur_r < rdata_r);

  assign sts.no_pass   = ((CW'(pass_r) + CW'(1)) >= fill_r);
  assign sts.last_step = ((j_r - AW'(1)) == pass_r);
  assign sts.swapped   = swapped_r;
  assign sts.out_last  = (k_r == fill_m1[AW-1:0]);

  // Store port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_r[AW-1:0];
    wr_data = in_value;
    rd_en   = 1'b1;
    rd_addr = k_r;
    if (cmd.store) begin
      wr_en = !full;
    end else if (cmd.step) begin
      wr_en   = 1'b1;
      wr_addr = j_r;
      wr_data = swap_now ? rdata_r : cur_r;
    end else if (cmd.pass_end) begin
      wr_en   = 1'b1;
      wr_addr = pass_r;
      wr_data = cur_r;
    end
    if (cmd.pass_start) begin
      rd_addr = fill_m1[AW-1:0];
    end else if (cmd.pass_first) begin
      rd_addr = j_r - AW'(1);
    end else if (cmd.step) begin
      rd_addr = j_r - AW'(2);
    end else if (!cmd.out_read) begin
      rd_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= store_mem[rd_addr];
    end
  end

  always_comb begin
    fill_nxt    = fill_r;
    pass_nxt    = pass_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    swapped_nxt = swapped_r;
    cmp_nxt     = cmp_r;
    swp_nxt     = swp_r;
    cur_nxt     = cur_r;
    if (cmd.store && !full) begin
      fill_nxt = fill_r + CW'(1);
    end
    if (cmd.pass_start) begin
      j_nxt       = fill_m1[AW-1:0];
      swapped_nxt = 1'b0;
    end
    if (cmd.pass_first) begin
      cur_nxt = rdata_r;
    end
    if (cmd.step) begin
      j_nxt   = j_r - AW'(1);
      cmp_nxt = (cmp_r == bsc_pkg::TOTAL_MAX) ? cmp_r : cmp_r + TW'(1);
      if (swap_now) begin
        swapped_nxt = 1'b1;
        swp_nxt     = (swp_r == bsc_pkg::TOTAL_MAX) ? swp_r : swp_r + TW'(1);
      end else begin
        cur_nxt = rdata_r;
      end
    end
    if (cmd.pass_end) begin
      pass_nxt = pass_r + AW'(1);
    end
    if (cmd.out_next) begin
      k_nxt = k_r + AW'(1);
    end
    if (cmd.clear) begin
      fill_nxt    = '0;
      pass_nxt    = '0;
      k_nxt       = '0;
      swapped_nxt = 1'b1;
      cmp_nxt     = '0;
      swp_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      pass_r    <= '0;
      k_r       <= '0;
      swapped_r <= 1'b1;
      cmp_r     <= '0;
      swp_r     <= '0;
    end else begin
      fill_r    <= fill_nxt;
      pass_r    <= pass_nxt;
      k_r       <= k_nxt;
      swapped_r <= swapped_nxt;
      cmp_r     <= cmp_nxt;
      swp_r     <= swp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r   <= j_nxt;
    cur_r <= cur_nxt;
  end

  assign out_value    = rdata_r;
  assign out_last     = sts.out_last;
  assign out_compares = cmp_r;
  assign out_swaps    = swp_r;

  // A compare step always lies above the pass boundary.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (j_r > pass_r))
    else $error("compare step at or below the pass index");

  // Every swap follows a compare.
  a_swap_le_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    swp_r <= cmp_r)
    else $error("swap total exceeds compare total");

  // A pass is only started on a non-empty set.
  a_pass_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pass_start |-> (fill_r != '0))
    else $error("sort pass on an empty set");

endmodule

@@ sv/bubble_sort_with_counts.sv @@
// Top level of the counting bubble sorter: channels, controller and datapath.
//
// Usage:
//   in_ch carries one signed 32-bit item_value per item; the item with
//   is_last set closes the set. Up to MAX_ITEMS values are kept, and later
//   values of an overfull set are dropped (an is_last mark still closes it).
//   After the closing item the block sorts the set ascending with an
//   early-exit bubble sort, then emits one result per stored value on
//   out_ch, lowest first, last_out on the final one. Every result carries
//   the set's compare_total and swap_total (saturating at their maximum).
// Sorting a set:
//   load takes one item per cycle; each pass p reads and captures the top
//   entry, makes one compare per cycle through the single store read port
//   down to entry p+1, then writes the carried value to entry p; output
//   reads each result from the store (store read), then shows it until
//   the receiver takes it.
//   in_ch.ready is low from the closing item until the last result leaves.
// Reset clears the control state and counts; the store holds stale data,
//   but only entries written for the current set are ever read.
// A stalled receiver holds the shown result and freezes the sequencer.
module bubble_sort_with_counts (
  input  logic             clk,
  input  logic             rst_n,
  bsc_in_if.sink           in_ch,
  bsc_out_if.source        out_ch
);

  bsc_pkg::cmd_t cmd;
  bsc_pkg::sts_t sts;

  // Sequencer: drives both handshakes and steps the datapath.
  bsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_is_last (in_ch.is_last),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath: store, carried value and counts; result payload comes from
  // its registers and holds while the receiver stalls.
  bsc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_value     (in_ch.item_value),
    .out_value    (out_ch.sorted_value),
    .out_last     (out_ch.last_out),
    .out_compares (out_ch.compare_total),
    .out_swaps    (out_ch.swap_total)
  );

endmodule

@@ sim/bsc_checker.sv @@
// Checker for the counting bubble sorter: predicts each sorted set and compares results.
module bsc_checker (
  input  logic clk,
  input  logic rst_n,
  bsc_in_if    in_mon,
  bsc_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import bsc_pkg::*;

  typedef struct {
    logic signed [VAL_W-1:0]   sorted_value;
    logic                      last_out;
    logic        [TOTAL_W-1:0] compare_total;
    logic        [TOTAL_W-1:0] swap_total;
  } sorted_result_t;

  logic signed [VAL_W-1:0] set_values [MAX_ITEMS];
  int                      set_fill;
  sorted_result_t          sorted_results [$];
  int                      mismatches;
  int                      results_seen;

  task automatic flag_mismatch(input string what, input logic signed [VAL_W-1:0] got,
                               input logic signed [VAL_W-1:0] want);
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Early-exit bubble sort of the collected set, with saturating totals.
  function automatic void sort_and_queue(input int n);
    logic        [TOTAL_W-1:0] compares;
    logic        [TOTAL_W-1:0] swaps;
    logic signed [VAL_W-1:0]   held;
    bit                        swapped;
    int                        pass;
    sorted_result_t            res;
    compares = '0;
    swaps    = '0;
    swapped  = 1'b1;
    pass     = 0;
    while (pass < n && swapped) begin
      swapped = 1'b0;
      for (int j = n - 1; j > pass; j--) begin
        if (compares != TOTAL_MAX) compares++;
        if (set_values[j] < set_values[j-1]) begin
          held            = set_values[j-1];
          set_values[j-1] = set_values[j];
          set_values[j]   = held;
          if (swaps != TOTAL_MAX) swaps++;
          swapped = 1'b1;
        end
      end
      pass++;
    end
    for (int k = 0; k < n; k++) begin
      res.sorted_value  = set_values[k];
      res.last_out      = (k == n - 1);
      res.compare_total = compares;
      res.swap_total    = swaps;
      sorted_results.push_back(res);
    end
  endfunction

  always @(posedge clk) begin
    sorted_result_t want;
    if (!rst_n) begin
      set_fill = 0;
      sorted_results.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        // drop values past the store depth; the mark still closes the set
        if (set_fill < MAX_ITEMS) begin
          set_values[set_fill] = in_mon.item_value;
          set_fill++;
        end
        if (in_mon.is_last) begin
          sort_and_queue(set_fill);
          set_fill = 0;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        results_seen++;
        if (sorted_results.size() == 0) begin
          flag_mismatch("result with none expected", out_mon.sorted_value, 0);
        end else begin
          want = sorted_results.pop_front();
          if (out_mon.sorted_value !== want.sorted_value)
            flag_mismatch("sorted_value", out_mon.sorted_value, want.sorted_value);
          if (out_mon.last_out !== want.last_out)
            flag_mismatch("last_out", out_mon.last_out, want.last_out);
          if (out_mon.compare_total !== want.compare_total)
            flag_mismatch("compare_total", out_mon.compare_total, want.compare_total);
          if (out_mon.swap_total !== want.swap_total)
            flag_mismatch("swap_total", out_mon.swap_total, want.swap_total);
        end
      end
    end
    fail_count   <= mismatches;
    pending      <= sorted_results.size();
    result_count <= results_seen;
  end

endmodule

@@ sim/tb_bubble_sort_with_counts.sv @@
// Top of the counting bubble sorter testbench: clock, reset, stimulus and verdict.
module tb_bubble_sort_with_counts;
  timeunit 1ns;
  timeprecision 1ps;
  import bsc_pkg::*;

  localparam int ITEM_TARGET  = 500;
  localparam int HOLD_CYCLES  = 600;    // long receiver hold-off
  localparam int IDLE_LIMIT   = 20000;  // cycles with no item moved before the watchdog ends the run
  localparam int DRAIN_CYCLES = 200;

  localparam logic signed [VAL_W-1:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] V_MAX = 32'sh7fff_ffff;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD} idle_phase_t;
  typedef enum int {VM_FULL, VM_NARROW, VM_UP, VM_DOWN, VM_EDGE} value_mix_t;

  logic        clk;
  logic        rst_n;
  int          fail_count;
  int          pending;
  int          result_count;
  int          items_sent;
  int          sets_sent;
  int          quiet_cycles;
  idle_phase_t phase;
  int          send_idle_pct;
  int          stall_pct;
  bit          hold_done;

  bsc_in_if  in_ch();
  bsc_out_if out_ch();

  bubble_sort_with_counts u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The checker watches both channels and owns all prediction.
  bsc_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run when neither channel moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[%0t] watchdog: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Pick the idle mix for both sides; the hold phase stalls only through the hold-off.
  task automatic set_phase(input idle_phase_t p);
    phase = p;
    case (p)
      PH_SEND_IDLE: begin
        send_idle_pct = 62;
        stall_pct     = 0;
      end
      PH_RECV_STALL: begin
        send_idle_pct = 0;
        stall_pct     = 62;
      end
      PH_BOTH: begin
        send_idle_pct = 10;
        stall_pct     = 10;
      end
      default: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
    endcase
  endtask

  // Receiver: stall at random, and once, in the hold phase, hold off for a
  // long stretch so the sorter backs up and keeps its input stalled.
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (phase == PH_HOLD && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  // Offer one item after a random idle gap; hold it until accepted.
  task automatic send_item(input logic signed [VAL_W-1:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.item_value <= value;
    in_ch.is_last    <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Send a whole set, marking the final value.
  task automatic send_list(input logic signed [VAL_W-1:0] vals [$]);
    foreach (vals[k]) send_item(vals[k], k == vals.size() - 1);
    sets_sent++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value(input value_mix_t mix, input int k);
    int pick;
    pick = $urandom_range(4);
    case (mix)
      VM_NARROW: return $urandom_range(8) - 4;       // lots of duplicates
      VM_UP:     return k * 37 - 1000;               // already in order
      VM_DOWN:   return 1000 - k * 37;               // worst case, reversed
      VM_EDGE: begin
        case (pick)
          0:       return V_MIN;
          1:       return V_MAX;
          2:       return 0;
          3:       return -1;
          default: return 1;
        endcase
      end
      default:   return $urandom;
    endcase
  endfunction

  // Stimulus: directed sets, then random sets across the idle phases.
  initial begin
    logic signed [VAL_W-1:0] vals [$];
    value_mix_t              mix;
    int                      n;
    int                      kind;
    int                      set_idx;
    in_ch.valid      <= 1'b0;
    in_ch.item_value <= '0;
    in_ch.is_last    <= 1'b0;
    rst_n            <= 1'b0;
    items_sent = 0;
    sets_sent  = 0;
    hold_done  = 1'b0;
    set_phase(PH_FREE);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single values: no comparison, last_out set, both totals zero.
    vals = '{V_MIN};
    send_list(vals);
    vals = '{V_MAX};
    send_list(vals);
    // Extremes out of order, then a fully reversed set of four.
    vals = '{V_MAX, V_MIN};
    send_list(vals);
    vals = '{V_MAX, 0, -1, V_MIN};
    send_list(vals);
    // Equal values never swap; an ordered set exits after one pass.
    vals = '{5, 5};
    send_list(vals);
    vals = '{-3, 0, 7};
    send_list(vals);
    vals = '{9, 2, 4, -8};
    send_list(vals);

    // Random part: mostly small sets, a few large, reversed and overfull ones.
    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      if (set_idx == 12) set_phase(PH_HOLD);
      else set_phase(idle_phase_t'((set_idx / 3) % 4));
      kind = (set_idx == 2) ? 0 : (set_idx == 5) ? 1 : $urandom_range(19);
      mix  = value_mix_t'($urandom_range(4));
      if (phase == PH_HOLD) begin
        n = 20;
      end else if (kind == 0) begin
        n   = MAX_ITEMS;
        mix = VM_DOWN;        // most compares and swaps
      end else if (kind == 1) begin
        n = MAX_ITEMS + $urandom_range(1, 4);   // store full, extra values dropped
      end else if (kind < 5) begin
        n = $urandom_range(9, 40);
      end else begin
        n = $urandom_range(1, 8);
      end
      vals.delete();
      for (int k = 0; k < n; k++) vals.push_back(pick_value(mix, k));
      send_list(vals);
      set_idx++;
    end

    // Drain: stop offering, wait for every expected result, then linger.
    in_ch.valid <= 1'b0;
    set_phase(PH_FREE);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items in %0d sets of 1 to %0d values; checked %0d results.",
             items_sent, sets_sent, MAX_ITEMS + 4, result_count);
    $display("Covered free, sender-idle, receiver-stall and mixed phases and one long hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ bubble_sort_with_counts.f @@
sv/bsc_pkg.sv
sv/bsc_if.sv
sv/bsc_ctrl.sv
sv/bsc_dp.sv
sv/bubble_sort_with_counts.sv
sim/bsc_checker.sv
sim/tb_bubble_sort_with_counts.sv
